/* design/stps_pkg.sv */
// Package for the stepper phase sequencer: widths, register indexes, reset values,
// the pipeline word carried between divider cells and the coil pattern lookup.
// No dependencies.
package stps_pkg;

  localparam int unsigned ANGLE_W = 19;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NCELL   = ANGLE_W;

  localparam logic [ANGLE_W-1:0] ANGLE_RST = ANGLE_W'(1800);
  localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(1000);

  localparam logic REG_STEP_ANGLE = 1'b0;
  localparam logic REG_MAX_SPEED  = 1'b1;

  localparam logic [IDX_W-1:0] LAST_FULL = IDX_W'(3);
  localparam logic [IDX_W-1:0] LAST_HALF = IDX_W'(7);

  localparam logic [COIL_W-1:0] SEQ_FULL [4] = '{4'h8, 4'h4, 4'h2, 4'h1};
  localparam logic [COIL_W-1:0] SEQ_HALF [8] =
    '{4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  typedef struct packed {
    logic               vld;
    logic               ccw;
    logic               half;
    logic [ANGLE_W-1:0] dq;
    logic [SPEED_W-1:0] rem;
    logic [SPEED_W-1:0] dvs;
  } stps_word_t;

  function automatic logic [COIL_W-1:0] coil_pat(input logic ccw, input logic half,
                                                 input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] pos;
    pos = ccw ? ((half ? LAST_HALF : LAST_FULL) - idx) : idx;
    return half ? SEQ_HALF[pos] : SEQ_FULL[pos[1:0]];
  endfunction

endpackage

/* design/stps_cmd_if.sv */
// Command channel of the stepper phase sequencer: handshake and command fields.
// Depends on stps_pkg.
interface stps_cmd_if
  import stps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               func;
  logic               half_step;
  logic [SPEED_W-1:0] speed;

  modport source (output valid, func, half_step, speed, input ready);
  modport sink (input valid, func, half_step, speed, output ready);
endinterface

/* design/stps_res_if.sv */
// Result channel of the stepper phase sequencer: handshake and coil pattern fields.
// Depends on stps_pkg.
interface stps_res_if
  import stps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COIL_W-1:0]  coil;
  logic [ANGLE_W-1:0] hold_ms;
  logic               last;

  modport source (output valid, coil, hold_ms, last, input ready);
  modport sink (input valid, coil, hold_ms, last, output ready);
endinterface

/* design/stps_div_cell.sv */
// One cell of the restoring divider chain: produces one quotient bit per word.
// Depends on stps_pkg.
module stps_div_cell
  import stps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  stps_word_t word_i,
  output stps_word_t word_o
);

  logic               vld_q;
  stps_word_t         data_q;
  stps_word_t         data_d;
  logic [SPEED_W:0]   trial;
  logic               ge;

  always_comb begin
    trial       = {word_i.rem, word_i.dq[ANGLE_W-1]};
    ge          = trial >= {1'b0, word_i.dvs};
    data_d      = word_i;
    data_d.dq   = {word_i.dq[ANGLE_W-2:0], ge};
    data_d.rem  = ge ? SPEED_W'(trial - {1'b0, word_i.dvs}) : trial[SPEED_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= word_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    word_o     = data_q;
    word_o.vld = vld_q;
  end

endmodule

/* design/stps_emit.sv */
// Result emitter: holds one finished command and plays out its coil patterns.
// Depends on stps_pkg and stps_res_if.
module stps_emit
  import stps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stps_word_t word_i,
  output logic       take_o,
  stps_res_if.source res
);

  logic               vld_q;
  logic [IDX_W-1:0]   idx_q;
  logic               ccw_q;
  logic               half_q;
  logic [ANGLE_W-1:0] hold_q;
  logic               last;

  assign last   = idx_q == (half_q ? LAST_HALF : LAST_FULL);
  assign take_o = word_i.vld && (!vld_q || (res.ready && last));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (take_o) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (vld_q && res.ready) begin
      if (last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      ccw_q  <= word_i.ccw;
      half_q <= word_i.half;
      hold_q <= word_i.half ? (word_i.dq >> 1) : word_i.dq;
    end
  end

  assign res.valid   = vld_q;
  assign res.coil    = coil_pat(ccw_q, half_q, idx_q);
  assign res.hold_ms = hold_q;
  assign res.last    = last;

`ifndef NO_ASSERTIONS
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && res.ready && !last) |=> (vld_q && $stable(hold_q)))
    else $error("emitter dropped a run before its final word");
  a_full_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !half_q) |-> !idx_q[IDX_W-1])
    else $error("full-step run index out of range");
`endif

endmodule

/* design/stps_core.sv */
// Top level of the stepper phase sequencer: configuration registers, speed clamp,
// divider cell chain and result emitter. Depends on stps_pkg, interfaces and cells.
module stepper_phase_sequencer_core
  import stps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [ANGLE_W-1:0] cfg_wdata_i,
  stps_cmd_if.sink           cmd,
  stps_res_if.source         res
);
  // Each command passes a chain of 19 divider cells, one quotient bit per cell,
  // after which the emitter registers it and offers its first word. It yields 4 or 8
  // words, one per cycle while the result side is ready, and the next command
  // follows directly when it is already waiting at the end of the chain.

  logic [ANGLE_W-1:0] angle_q;
  logic [SPEED_W-1:0] max_q;
  logic [SPEED_W-1:0] lim;
  logic [SPEED_W-1:0] spd;
  logic               take;
  logic               adv;
  stps_word_t         chain [NCELL+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= ANGLE_RST;
      max_q   <= SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_ANGLE: angle_q <= cfg_wdata_i;
        REG_MAX_SPEED:  max_q   <= cfg_wdata_i[SPEED_W-1:0];
        default:        angle_q <= angle_q;
      endcase
    end
  end

  assign lim = (max_q == '0) ? SPEED_W'(1) : max_q;
  assign spd = (cmd.speed == '0) ? SPEED_W'(1) : cmd.speed;

  assign adv       = !chain[NCELL].vld || take;
  assign cmd.ready = adv;

  always_comb begin
    chain[0].vld  = cmd.valid;
    chain[0].ccw  = cmd.func;
    chain[0].half = cmd.half_step;
    chain[0].dq   = angle_q;
    chain[0].rem  = '0;
    chain[0].dvs  = (spd > lim) ? lim : spd;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    stps_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .word_i (chain[i]),
      .word_o (chain[i+1])
    );
  end

  stps_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (chain[NCELL]),
    .take_o (take),
    .res    (res)
  );

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(chain[NCELL].vld) && $stable(chain[1].vld)))
    else $error("divider chain moved while stalled");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.valid && cmd.ready) |=> chain[1].vld)
    else $error("accepted command did not enter the chain");
`endif

endmodule

/* verif/tb.sv */
// Testbench for stepper_phase_sequencer_core: drives rotation commands and register writes,
// and checks every coil word against a scoreboard that predicts the pattern runs.
// Depends on stps_pkg, stps_cmd_if, stps_res_if and the design sources.
module tb;
  import stps_pkg::*;

  typedef enum bit {DIR_CW = 1'b0, DIR_CCW = 1'b1} dir_e;

  localparam int unsigned IDLE_PCT       = 11;
  localparam int unsigned DRAIN_CYCLES   = 64;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned MAX_SHOWN      = 50;
  localparam int unsigned RAND_PHASES    = 6;
  localparam int unsigned RAND_PER_PHASE = 60;

  typedef struct packed {
    logic [COIL_W-1:0]  coil;
    logic [ANGLE_W-1:0] hold;
    logic               last;
  } coil_word_t;

  class coil_run_board;
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] limit;
    coil_word_t         pending[$];
    int unsigned        errors;
    int unsigned        commands;
    int unsigned        words;
    logic [COIL_W-1:0]  full_cw [4];
    logic [COIL_W-1:0]  half_cw [8];

    function new();
      angle    = ANGLE_W'(1800);
      limit    = SPEED_W'(1000);
      errors   = 0;
      commands = 0;
      words    = 0;
      full_cw  = '{4'h8, 4'h4, 4'h2, 4'h1};
      half_cw  = '{4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};
    endfunction

    function void set_reg(logic idx, logic [ANGLE_W-1:0] data);
      if (idx == REG_STEP_ANGLE) begin
        angle = data;
      end else begin
        limit = data[SPEED_W-1:0];
      end
    endfunction

    function void note_command(dir_e dir, logic half, logic [SPEED_W-1:0] speed);
      logic [SPEED_W-1:0] rate;
      logic [SPEED_W-1:0] lim;
      logic [ANGLE_W-1:0] hold;
      int                 n;
      int                 pos;
      coil_word_t         w;
      rate = (speed == 0) ? SPEED_W'(1) : speed;
      lim  = (limit == 0) ? SPEED_W'(1) : limit;
      if (rate > lim) begin
        rate = lim;
      end
      hold = angle / rate;
      if (half) begin
        hold = hold >> 1;
      end
      n = half ? 8 : 4;
      for (int k = 0; k < n; k++) begin
        pos    = (dir == DIR_CCW) ? (n - 1 - k) : k;
        w.coil = half ? half_cw[pos] : full_cw[pos];
        w.hold = hold;
        w.last = (k == n - 1);
        pending.push_back(w);
      end
      commands++;
    endfunction

    function void check_word(logic [COIL_W-1:0] coil, logic [ANGLE_W-1:0] hold, logic last);
      coil_word_t got;
      coil_word_t want;
      got = '{coil, hold, last};
      words++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN) begin
          $display("%0t: unexpected word, expected none, actual coil=%h hold=%0d last=%b",
                   $time, got.coil, got.hold, got.last);
        end
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= MAX_SHOWN) begin
            $display("%0t: mismatch, expected coil=%h hold=%0d last=%b, actual coil=%h hold=%0d last=%b",
                     $time, want.coil, want.hold, want.last, got.coil, got.hold, got.last);
          end
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [ANGLE_W-1:0] cfg_wdata_i;

  stps_cmd_if cmd_ch ();
  stps_res_if res_ch ();

  coil_run_board sb;
  bit            quiet       = 1'b0;
  bit            holdoff_req = 1'b0;
  int unsigned   settings    = 1;
  int unsigned   cycles      = 0;

  stepper_phase_sequencer_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd        (cmd_ch),
    .res        (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready) begin
        sb.check_word(res_ch.coil, res_ch.hold_ms, res_ch.last);
      end
      if (stall_left != 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (holdoff_req) begin
        holdoff_req = 1'b0;
        stall_left  = HOLDOFF_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_cmd(dir_e dir, logic half, logic [SPEED_W-1:0] speed);
    while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.func      <= dir;
    cmd_ch.half_step <= half;
    cmd_ch.speed     <= speed;
    @(posedge clk_i);
    while (!cmd_ch.ready) begin
      @(posedge clk_i);
    end
    sb.note_command(dir, half, speed);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [ANGLE_W-1:0] angle, logic [ANGLE_W-1:0] limit_word);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_STEP_ANGLE;
    cfg_wdata_i <= angle;
    @(posedge clk_i);
    sb.set_reg(REG_STEP_ANGLE, angle);
    cfg_idx_i   <= REG_MAX_SPEED;
    cfg_wdata_i <= limit_word;
    @(posedge clk_i);
    sb.set_reg(REG_MAX_SPEED, limit_word);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  function automatic logic [SPEED_W-1:0] pick_speed();
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;
    sel = $urandom_range(9);
    lo  = (sb.limit > 3) ? sb.limit - 3 : 0;
    hi  = (sb.limit + 3 > 65535) ? 65535 : sb.limit + 3;
    if (sel < 3) begin
      return SPEED_W'($urandom_range(hi, lo));
    end else if (sel < 5) begin
      return SPEED_W'($urandom_range(15));
    end
    return SPEED_W'($urandom);
  endfunction

  initial begin : main
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] limit_word;
    sb = new();
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_STEP_ANGLE;
    cfg_wdata_i      <= '0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.func      <= DIR_CW;
    cmd_ch.half_step <= 1'b0;
    cmd_ch.speed     <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset register values: zero speed, limit edges and all four sequences.
    send_cmd(DIR_CW,  1'b0, 16'd0);
    send_cmd(DIR_CCW, 1'b0, 16'd1);
    send_cmd(DIR_CW,  1'b1, 16'd1000);
    send_cmd(DIR_CCW, 1'b1, 16'd1001);
    send_cmd(DIR_CW,  1'b0, 16'hFFFF);
    send_cmd(DIR_CCW, 1'b1, 16'd333);
    send_cmd(DIR_CW,  1'b1, 16'd7);
    send_cmd(DIR_CCW, 1'b0, 16'd500);
    drain();

    // Zero step angle together with a zero limit.
    configure('0, '0);
    send_cmd(DIR_CW,  1'b1, 16'd0);
    send_cmd(DIR_CCW, 1'b0, 16'hFFFF);
    drain();

    // Step angle above the nominal range, widest limit.
    configure('1, ANGLE_W'(16'hFFFF));
    send_cmd(DIR_CW,  1'b1, 16'd1);
    send_cmd(DIR_CCW, 1'b0, 16'd1);
    send_cmd(DIR_CCW, 1'b1, 16'hFFFF);
    send_cmd(DIR_CW,  1'b0, 16'd2);
    drain();

    configure(ANGLE_W'(360000), ANGLE_W'(1));
    send_cmd(DIR_CW,  1'b1, 16'd40000);
    send_cmd(DIR_CCW, 1'b0, 16'd0);
    drain();

    configure(ANGLE_W'(1), ANGLE_W'(16'hFFFF));
    send_cmd(DIR_CCW, 1'b1, 16'd1);
    send_cmd(DIR_CW,  1'b0, 16'd1);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(7))
        0:       angle = '0;
        1:       angle = ANGLE_W'(1);
        2:       angle = ANGLE_W'(360000);
        3:       angle = '1;
        default: angle = ANGLE_W'($urandom_range(360000, 1));
      endcase
      case ($urandom_range(7))
        0:       limit_word[SPEED_W-1:0] = '0;
        1:       limit_word[SPEED_W-1:0] = SPEED_W'(1);
        2:       limit_word[SPEED_W-1:0] = '1;
        default: limit_word[SPEED_W-1:0] = SPEED_W'($urandom_range(65535, 1));
      endcase
      limit_word[ANGLE_W-1:SPEED_W] = ($urandom_range(1) != 0) ? '1 : '0;
      configure(angle, limit_word);
      if (p == 1) begin
        holdoff_req = 1'b1;
      end
      quiet = (p == 3);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        send_cmd(dir_e'($urandom_range(1)), 1'($urandom_range(1)), pick_speed());
      end
      drain();
      quiet = 1'b0;
    end

    $display("Ran %0d rotation commands and checked %0d coil words under %0d register settings,",
             sb.commands, sb.words, settings);
    $display("covering zero speed and limit, zero and oversized step angles, and a long output stall.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/stps_pkg.sv
design/stps_cmd_if.sv
design/stps_res_if.sv
design/stps_div_cell.sv
design/stps_emit.sv
design/stps_core.sv
verif/tb.sv
